// ===== src/i2c_ms_pkg.sv =====
package i2c_ms_pkg;

  localparam logic [2:0] MODE_RELEASE      = 3'd0;
  localparam logic [2:0] MODE_START        = 3'd1;
  localparam logic [2:0] MODE_STOP         = 3'd2;
  localparam logic [2:0] MODE_WRITE_BYTE   = 3'd3;
  localparam logic [2:0] MODE_READ_BYTE    = 3'd4;
  localparam logic [2:0] MODE_WRITE_ACK    = 3'd5;
  localparam logic [2:0] MODE_READ_ACK     = 3'd6;
  localparam logic [2:0] MODE_READ_STRETCH = 3'd7;

  localparam int unsigned STEP_W = 5;
  localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;

  typedef logic [STEP_W-1:0] step_t;

  function automatic step_t last_step(input logic [2:0] mode);
    step_t s;
    unique case (mode)
      MODE_RELEASE:      s = step_t'(0);
      MODE_START:        s = step_t'(2);
      MODE_STOP:         s = step_t'(2);
      MODE_WRITE_BYTE:   s = step_t'(24);
      MODE_READ_BYTE:    s = step_t'(16);
      MODE_WRITE_ACK:    s = step_t'(4);
      MODE_READ_ACK:     s = step_t'(3);
      MODE_READ_STRETCH: s = step_t'(0);
      default:           s = step_t'(0);
    endcase
    return s;
  endfunction

endpackage

// ===== src/i2c_ms_if.sv =====
interface i2c_ms_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] data_byte;
  logic       ack_level;
  logic [7:0] sda_samples;
  logic       scl_sample;

  modport source (output valid, mode, data_byte, ack_level, sda_samples, scl_sample,
                  input ready);
  modport sink (input valid, mode, data_byte, ack_level, sda_samples, scl_sample,
                output ready);
endinterface

interface i2c_ms_res_if;
  logic       valid;
  logic       ready;
  logic       sda_level;
  logic       scl_level;
  logic [7:0] read_value;
  logic       last;

  modport source (output valid, sda_level, scl_level, read_value, last, input ready);
  modport sink (input valid, sda_level, scl_level, read_value, last, output ready);
endinterface

// ===== src/i2c_master_bit_sequencer_core.sv =====
// I2C master line sequencer. Each command word taken on cmd is expanded into a run of
// half-period words on res, one word per SCL half period, giving the open-drain SDA/SCL
// drive levels (1 released); the final word of a command carries last and the read value.
// A command is held in a small sequencer with a step counter and a byte shift register
// that moves out one data bit every three half periods. Within a command the words are
// spaced by the divider counter, reloaded from half_period after each word (0 acts as 1),
// plus any stall on the output, and a command takes 1 to 25 such words (write byte 25, read
// byte 17, or 16 after a stretch). A new command can be accepted in the cycle after the last
// word of the previous one is loaded into the output register, and its first word does not
// wait on the divider, whatever half_period is, only on the output being free. cmd is
// not ready during reset. half_period resets to 5 and only affects timing.
module i2c_master_bit_sequencer_core (
  input  logic                clk,
  input  logic                rst,
  i2c_ms_cmd_if.sink          cmd,
  i2c_ms_res_if.source        res,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  logic [7:0]          half_period;
  logic                busy;
  logic [2:0]          mode_r;
  logic [7:0]          data_sh;
  logic                ack_r;
  logic [7:0]          samples_r;
  logic                sclin_r;
  i2c_ms_pkg::step_t   step;
  logic [1:0]          ph;
  logic [7:0]          div;
  logic                prev_sda;
  logic                prev_scl;
  logic                stretch_pending;
  logic                res_valid;

  logic                in_acc;
  logic                emit;
  logic                item_sda;
  logic                item_scl;
  logic                item_last;
  logic [7:0]          item_value;

  assign cmd.ready = !busy && !rst;
  assign in_acc    = cmd.valid && cmd.ready;
  assign emit      = busy && (div == 8'd0) && (!res_valid || res.ready);
  assign res.valid = res_valid;
  assign item_last = (step == i2c_ms_pkg::last_step(mode_r));

  always_comb begin
    item_sda = 1'b1;
    item_scl = 1'b1;
    unique case (mode_r)
      i2c_ms_pkg::MODE_RELEASE: begin
        item_sda = 1'b1;
        item_scl = 1'b1;
      end
      i2c_ms_pkg::MODE_START: begin
        item_sda = (step != i2c_ms_pkg::step_t'(2));
        item_scl = (step == i2c_ms_pkg::step_t'(0)) ? prev_scl : 1'b1;
      end
      i2c_ms_pkg::MODE_STOP: begin
        item_sda = (step == i2c_ms_pkg::step_t'(2));
        item_scl = (step == i2c_ms_pkg::step_t'(0)) ? prev_scl : 1'b1;
      end
      i2c_ms_pkg::MODE_WRITE_BYTE: begin
        item_sda = (step == i2c_ms_pkg::step_t'(0)) ? prev_sda : data_sh[7];
        item_scl = (step != i2c_ms_pkg::step_t'(0)) && (ph == 2'd1);
      end
      i2c_ms_pkg::MODE_READ_BYTE: begin
        item_sda = (step == i2c_ms_pkg::step_t'(0)) ? prev_sda : 1'b1;
        item_scl = step[0];
      end
      i2c_ms_pkg::MODE_WRITE_ACK: begin
        priority if (step == i2c_ms_pkg::step_t'(0)) item_sda = prev_sda;
        else if (step == i2c_ms_pkg::step_t'(4))     item_sda = 1'b1;
        else                                         item_sda = ack_r;
        item_scl = (step == i2c_ms_pkg::step_t'(2));
      end
      i2c_ms_pkg::MODE_READ_ACK: begin
        item_sda = (step == i2c_ms_pkg::step_t'(0)) ? prev_sda : 1'b1;
        item_scl = (step == i2c_ms_pkg::step_t'(2));
      end
      i2c_ms_pkg::MODE_READ_STRETCH: begin
        item_sda = prev_sda;
        item_scl = 1'b1;
      end
      default: begin
        item_sda = 1'b1;
        item_scl = 1'b1;
      end
    endcase
  end

  always_comb begin
    item_value = 8'd0;
    if (item_last) begin
      priority case (mode_r)
        i2c_ms_pkg::MODE_READ_BYTE:    item_value = samples_r;
        i2c_ms_pkg::MODE_READ_ACK:     item_value = {7'd0, samples_r[7]};
        i2c_ms_pkg::MODE_READ_STRETCH: item_value = {7'd0, sclin_r};
        default:                       item_value = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2c_ms_pkg::HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      step            <= '0;
      ph              <= 2'd0;
      div             <= 8'd0;
      prev_sda        <= 1'b1;
      prev_scl        <= 1'b1;
      stretch_pending <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (in_acc) begin
        busy            <= 1'b1;
        div             <= 8'd0;
        ph              <= 2'd0;
        stretch_pending <= (cmd.mode == i2c_ms_pkg::MODE_READ_STRETCH);
        step            <= ((cmd.mode == i2c_ms_pkg::MODE_READ_BYTE) && stretch_pending)
                           ? i2c_ms_pkg::step_t'(1) : i2c_ms_pkg::step_t'(0);
      end else if (emit) begin
        prev_sda <= item_sda;
        prev_scl <= item_scl;
        div      <= (half_period == 8'd0) ? 8'd0 : half_period - 8'd1;
        if (item_last) begin
          busy <= 1'b0;
        end else begin
          step <= step + i2c_ms_pkg::step_t'(1);
        end
        if ((mode_r == i2c_ms_pkg::MODE_WRITE_BYTE) && (step != i2c_ms_pkg::step_t'(0))) begin
          ph <= (ph == 2'd2) ? 2'd0 : ph + 2'd1;
        end
      end else if (busy && (div != 8'd0)) begin
        div <= div - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r    <= cmd.mode;
      data_sh   <= cmd.data_byte;
      ack_r     <= cmd.ack_level;
      samples_r <= cmd.sda_samples;
      sclin_r   <= cmd.scl_sample;
    end else if (emit && (mode_r == i2c_ms_pkg::MODE_WRITE_BYTE) && (ph == 2'd2)) begin
      data_sh <= {data_sh[6:0], 1'b0};
    end
    if (emit) begin
      res.sda_level  <= item_sda;
      res.scl_level  <= item_scl;
      res.read_value <= item_value;
      res.last       <= item_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_from_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(in_acc))
    else $error("sequencer started without a command word");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step <= i2c_ms_pkg::last_step(mode_r)))
    else $error("step counter ran past the last half period");

  a_stretch_set: assert property (@(posedge clk) disable iff (rst)
    (emit && (mode_r == i2c_ms_pkg::MODE_READ_STRETCH)) |-> stretch_pending)
    else $error("stretch flag not set during read stretch");

  a_no_emit_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.ready) |-> !emit)
    else $error("output word overwritten while stalled");
`endif

endmodule

// ===== tb/i2c_master_bit_sequencer_core_tb.sv =====
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_core_tb;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned ITEM_TARGET = 160;

  typedef struct packed {
    logic       sda;
    logic       scl;
    logic [7:0] read_value;
    logic       last;
  } line_word_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  i2c_ms_cmd_if cmd_if();
  i2c_ms_res_if res_if();

  i2c_master_bit_sequencer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_if),
    .res       (res_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // bus state as the sequencer should see it
  logic       bus_sda;
  logic       bus_scl;
  logic       stretch_armed;
  logic [7:0] half_period_shadow;

  line_word_t  expected_words[$];
  int unsigned error_count = 0;
  int unsigned words_seen = 0;
  int unsigned cmds_sent = 0;
  int unsigned burst_left = 0;
  bit          sender_gaps = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned sink_cycle = 0;
  int unsigned sink_style = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: always ready, random stalls, or a fixed duty pattern
  always @(posedge clk) begin
    sink_cycle <= sink_cycle + 1;
    if (sink_cycle % 256 == 0) sink_style <= $urandom_range(0, 2);
    case (sink_style)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= ($urandom_range(0, 3) != 0);
      default: res_if.ready <= ((sink_cycle % 16) < 11);
    endcase
  end

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("mismatch at word %0d: %s expected %0h got %0h", words_seen, what, want, got);
    error_count++;
  endtask

  function automatic void drive_half(input logic sda, input logic scl);
    line_word_t w;
    bus_sda = sda;
    bus_scl = scl;
    w.sda = sda;
    w.scl = scl;
    w.read_value = 8'h00;
    w.last = 1'b0;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_line_words(input logic [2:0] mode, input logic [7:0] data_byte,
                                             input logic ack_level,
                                             input logic [7:0] sda_samples,
                                             input logic scl_sample);
    logic [7:0] value;
    line_word_t w;
    value = 8'h00;
    case (mode)
      i2c_ms_pkg::MODE_RELEASE: begin
        stretch_armed = 1'b0;
        drive_half(1'b1, 1'b1);
      end
      i2c_ms_pkg::MODE_START: begin
        stretch_armed = 1'b0;
        drive_half(1'b1, bus_scl);
        drive_half(1'b1, 1'b1);
        drive_half(1'b0, 1'b1);
      end
      i2c_ms_pkg::MODE_STOP: begin
        stretch_armed = 1'b0;
        drive_half(1'b0, bus_scl);
        drive_half(1'b0, 1'b1);
        drive_half(1'b1, 1'b1);
      end
      i2c_ms_pkg::MODE_WRITE_BYTE: begin
        stretch_armed = 1'b0;
        drive_half(bus_sda, 1'b0);
        for (int i = 7; i >= 0; i--) begin
          drive_half(data_byte[i], 1'b0);
          drive_half(data_byte[i], 1'b1);
          drive_half(data_byte[i], 1'b0);
        end
      end
      i2c_ms_pkg::MODE_READ_BYTE: begin
        if (stretch_armed) stretch_armed = 1'b0;
        else drive_half(bus_sda, 1'b0);
        for (int i = 0; i < 8; i++) begin
          drive_half(1'b1, 1'b1);
          drive_half(1'b1, 1'b0);
        end
        value = sda_samples;
      end
      i2c_ms_pkg::MODE_WRITE_ACK: begin
        stretch_armed = 1'b0;
        drive_half(bus_sda, 1'b0);
        drive_half(ack_level, 1'b0);
        drive_half(ack_level, 1'b1);
        drive_half(ack_level, 1'b0);
        drive_half(1'b1, 1'b0);
      end
      i2c_ms_pkg::MODE_READ_ACK: begin
        stretch_armed = 1'b0;
        drive_half(bus_sda, 1'b0);
        drive_half(1'b1, 1'b0);
        drive_half(1'b1, 1'b1);
        drive_half(1'b1, 1'b0);
        value = {7'd0, sda_samples[7]};
      end
      default: begin
        drive_half(bus_sda, 1'b1);
        value = {7'd0, scl_sample};
        stretch_armed = 1'b1;
      end
    endcase
    w = expected_words.pop_back();
    w.read_value = value;
    w.last = 1'b1;
    expected_words.push_back(w);
  endfunction

  // predict on every accepted command, then check every accepted word
  always @(posedge clk) begin
    line_word_t want;
    if (!rst) begin
      if (cmd_if.valid && cmd_if.ready)
        predict_line_words(cmd_if.mode, cmd_if.data_byte, cmd_if.ack_level,
                           cmd_if.sda_samples, cmd_if.scl_sample);
      if (res_if.valid && res_if.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 8'h00, {4'd0, res_if.sda_level,
                          res_if.scl_level, 1'b0, res_if.last});
        end else begin
          want = expected_words.pop_front();
          if (res_if.sda_level !== want.sda)
            report_mismatch("sda_level", {7'd0, want.sda}, {7'd0, res_if.sda_level});
          if (res_if.scl_level !== want.scl)
            report_mismatch("scl_level", {7'd0, want.scl}, {7'd0, res_if.scl_level});
          if (res_if.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, res_if.read_value);
          if (res_if.last !== want.last)
            report_mismatch("last", {7'd0, want.last}, {7'd0, res_if.last});
        end
        words_seen++;
      end
    end
  end

  task automatic send_cmd(input logic [2:0] mode, input logic [7:0] data_byte,
                          input logic ack_level, input logic [7:0] sda_samples,
                          input logic scl_sample);
    int unsigned gap;
    if (sender_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left != 0) burst_left--;
    cmd_if.valid       <= 1'b1;
    cmd_if.mode        <= mode;
    cmd_if.data_byte   <= data_byte;
    cmd_if.ack_level   <= ack_level;
    cmd_if.sda_samples <= sda_samples;
    cmd_if.scl_sample  <= scl_sample;
    do @(posedge clk); while (!cmd_if.ready);
    cmds_sent++;
  endtask

  // unused fields carry random junk
  task automatic send_mode(input logic [2:0] mode);
    send_cmd(mode, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic wait_bus_idle();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_half_period(input logic [7:0] value);
    wait_bus_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    half_period_shadow = value;
  endtask

  task automatic test_directed_commands();
    sender_gaps = 1'b0;
    send_cmd(i2c_ms_pkg::MODE_RELEASE, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_cmd(i2c_ms_pkg::MODE_START, 8'h00, 1'b0, 8'h00, 1'b0);
    send_cmd(i2c_ms_pkg::MODE_WRITE_BYTE, 8'hFF, 1'b1, 8'h00, 1'b0);
    send_cmd(i2c_ms_pkg::MODE_WRITE_BYTE, 8'h00, 1'b0, 8'hFF, 1'b1);
    send_cmd(i2c_ms_pkg::MODE_WRITE_BYTE, 8'hA5, 1'b0, 8'h5A, 1'b0);
    send_cmd(i2c_ms_pkg::MODE_READ_ACK, 8'h00, 1'b0, 8'h80, 1'b0);
    send_cmd(i2c_ms_pkg::MODE_READ_ACK, 8'hFF, 1'b1, 8'h7F, 1'b1);
    send_cmd(i2c_ms_pkg::MODE_READ_BYTE, 8'h00, 1'b0, 8'h00, 1'b0);
    send_cmd(i2c_ms_pkg::MODE_READ_BYTE, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_cmd(i2c_ms_pkg::MODE_WRITE_ACK, 8'hFF, 1'b0, 8'hFF, 1'b1);
    send_cmd(i2c_ms_pkg::MODE_WRITE_ACK, 8'h00, 1'b1, 8'h00, 1'b0);
    // stretch, then a byte read without its first low phase
    send_cmd(i2c_ms_pkg::MODE_READ_STRETCH, 8'hFF, 1'b1, 8'hFF, 1'b0);
    send_cmd(i2c_ms_pkg::MODE_READ_BYTE, 8'h00, 1'b0, 8'h3C, 1'b0);
    send_cmd(i2c_ms_pkg::MODE_READ_BYTE, 8'h00, 1'b0, 8'hC3, 1'b1);
    send_cmd(i2c_ms_pkg::MODE_READ_STRETCH, 8'h00, 1'b0, 8'h00, 1'b1);
    send_cmd(i2c_ms_pkg::MODE_READ_STRETCH, 8'h00, 1'b1, 8'h00, 1'b1);
    send_cmd(i2c_ms_pkg::MODE_READ_BYTE, 8'hFF, 1'b1, 8'h81, 1'b0);
    // a stretch cleared by other commands
    send_cmd(i2c_ms_pkg::MODE_READ_STRETCH, 8'h00, 1'b0, 8'hFF, 1'b0);
    send_cmd(i2c_ms_pkg::MODE_WRITE_BYTE, 8'h81, 1'b1, 8'hFF, 1'b1);
    send_cmd(i2c_ms_pkg::MODE_READ_BYTE, 8'h00, 1'b0, 8'h01, 1'b0);
    send_cmd(i2c_ms_pkg::MODE_READ_STRETCH, 8'h00, 1'b0, 8'h00, 1'b1);
    send_cmd(i2c_ms_pkg::MODE_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_cmd(i2c_ms_pkg::MODE_READ_BYTE, 8'h00, 1'b0, 8'h80, 1'b0);
    send_cmd(i2c_ms_pkg::MODE_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic send_transaction();
    int unsigned n;
    bit          reading;
    if ($urandom_range(0, 9) < 2) begin
      send_mode(3'($urandom));
    end else begin
      send_mode(i2c_ms_pkg::MODE_START);
      send_mode(i2c_ms_pkg::MODE_WRITE_BYTE);
      send_mode(i2c_ms_pkg::MODE_READ_ACK);
      n = $urandom_range(0, 3);
      reading = 1'($urandom);
      repeat (n) begin
        if (reading) begin
          if ($urandom_range(0, 1) == 0) send_mode(i2c_ms_pkg::MODE_READ_STRETCH);
          send_mode(i2c_ms_pkg::MODE_READ_BYTE);
          send_mode(i2c_ms_pkg::MODE_WRITE_ACK);
        end else begin
          send_mode(i2c_ms_pkg::MODE_WRITE_BYTE);
          send_mode(i2c_ms_pkg::MODE_READ_ACK);
        end
      end
      // sometimes a repeated start instead of a stop
      if ($urandom_range(0, 4) != 0) send_mode(i2c_ms_pkg::MODE_STOP);
    end
  endtask

  task automatic test_period_extremes();
    sender_gaps = 1'b1;
    write_half_period(8'd1);
    repeat (2) send_transaction();
    write_half_period(8'd255);
    send_mode(i2c_ms_pkg::MODE_START);
    send_mode(i2c_ms_pkg::MODE_WRITE_BYTE);
    send_mode(i2c_ms_pkg::MODE_READ_STRETCH);
    send_mode(i2c_ms_pkg::MODE_READ_BYTE);
    send_mode(i2c_ms_pkg::MODE_STOP);
    write_half_period(8'd0);
    repeat (2) send_transaction();
  endtask

  task automatic test_random_traffic();
    sender_gaps = 1'b1;
    while (cmds_sent < ITEM_TARGET) begin
      write_half_period(($urandom_range(0, 3) == 0) ? 8'($urandom_range(9, 40))
                                                  : 8'($urandom_range(1, 8)));
      repeat ($urandom_range(3, 8)) send_transaction();
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 8'h00;
    cmd_if.valid       <= 1'b0;
    cmd_if.mode        <= i2c_ms_pkg::MODE_RELEASE;
    cmd_if.data_byte   <= 8'h00;
    cmd_if.ack_level   <= 1'b0;
    cmd_if.sda_samples <= 8'h00;
    cmd_if.scl_sample  <= 1'b0;
    bus_sda            = 1'b1;
    bus_scl            = 1'b1;
    stretch_armed      = 1'b0;
    half_period_shadow = i2c_ms_pkg::HALF_PERIOD_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_commands();
    test_period_extremes();
    test_random_traffic();
    write_half_period(i2c_ms_pkg::HALF_PERIOD_RESET);
    send_transaction();

    wait_bus_idle();
    repeat ((half_period_shadow + 1) * 30 + 100) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch("words left over", 8'h00, 8'(expected_words.size()));
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
